### hdl/windowed_rms_peak_envelope_top_macros.svh
// Assertion macros for the windowed RMS / peak envelope block.
// Used by windowed_rms_peak_envelope_top; expects clk_i and rst_ni in scope.
`ifndef WINDOWED_RMS_PEAK_ENVELOPE_TOP_MACROS_SVH
`define WINDOWED_RMS_PEAK_ENVELOPE_TOP_MACROS_SVH

// Property checked on every clock edge outside reset.
`define WRPE_ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Condition that must never be seen outside reset.
`define WRPE_ASSERT_NEVER(name, expr, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

### hdl/wrpe_pkg.sv
// Shared types and constants of the windowed RMS / peak envelope block.
// No dependencies; imported by wrpe_iter and windowed_rms_peak_envelope_top.
package wrpe_pkg;

  // Field widths
  localparam int SAMPLE_BITS   = 16;
  localparam int WIN_W         = 16;
  localparam int CHAN_W        = 4;
  localparam int TOTAL_W       = 40;
  localparam int LEVEL_W       = 16;
  localparam int DEN_W         = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'd1;
  localparam logic [WIN_W-1:0]     WIN_RESET         = 16'd2400;
  localparam logic [CHAN_W-1:0]    CHAN_RESET        = 4'd1;

  // Item commands
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_FLUSH  = 1'b1;

  // Shared shift/subtract unit operation
  typedef enum logic {
    MODE_DIV,
    MODE_SQRT
  } iter_mode_e;

  typedef struct packed {
    logic       start;
    iter_mode_e mode;
  } iter_req_t;

  typedef struct packed {
    logic                          cmd;
    logic signed [SAMPLE_BITS-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] rms;
    logic [LEVEL_W-1:0] peak;
    logic [TOTAL_W-1:0] centre_frame;
    logic [WIN_W-1:0]   frame_count;
  } out_item_t;

endpackage

### hdl/wrpe_iter.sv
// Shared iterative shift/compare/subtract unit: restoring divide or integer
// square root, one quotient/root bit per cycle. Depends on wrpe_pkg.
module wrpe_iter #(
  parameter int NUM_W = 54,
  parameter int REM_W = 21,
  parameter int CNT_W = 6
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  wrpe_pkg::iter_req_t    req_i,
  input  logic [CNT_W-1:0]       steps_i,
  input  logic [NUM_W-1:0]       num_i,
  input  logic [wrpe_pkg::DEN_W-1:0] den_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [NUM_W-1:0]       res_o
);
  import wrpe_pkg::*;

  logic [NUM_W-1:0] num_q;
  logic [REM_W-1:0] rem_q;
  logic [NUM_W-1:0] res_q;
  logic [DEN_W-1:0] den_q;
  iter_mode_e       mode_q;
  logic [CNT_W-1:0] cnt_q;
  logic             done_q;

  logic [REM_W-1:0] part_rem;
  logic [REM_W-1:0] trial;
  logic [REM_W-1:0] diff;
  logic             ge;

  // One step: bring down the next digit, compare with the trial value
  always_comb begin
    unique case (mode_q)
      MODE_DIV: begin
        part_rem = {rem_q[REM_W-2:0], num_q[NUM_W-1]};
        trial    = REM_W'(den_q);
      end
      MODE_SQRT: begin
        part_rem = {rem_q[REM_W-3:0], num_q[NUM_W-1 -: 2]};
        trial    = {res_q[REM_W-3:0], 2'b01};
      end
      default: begin
        part_rem = '0;
        trial    = '0;
      end
    endcase
    ge   = (part_rem >= trial);
    diff = part_rem - trial;
  end

  // Sequencing: load on start, then one step per cycle until the count runs out
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q  <= '0;
      rem_q  <= '0;
      res_q  <= '0;
      den_q  <= '0;
      mode_q <= MODE_DIV;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (cnt_q != '0) begin
        rem_q <= ge ? diff : part_rem;
        res_q <= {res_q[NUM_W-2:0], ge};
        num_q <= (mode_q == MODE_DIV) ? (num_q << 1) : (num_q << 2);
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          done_q <= 1'b1;
        end
      end else if (req_i.start) begin
        num_q  <= num_i;
        rem_q  <= '0;
        res_q  <= '0;
        den_q  <= den_i;
        mode_q <= req_i.mode;
        cnt_q  <= steps_i;
      end
    end
  end

  assign busy_o = (cnt_q != '0);
  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hdl/windowed_rms_peak_envelope_top.sv
// Top level of the windowed RMS / peak envelope block: channels, sequencer,
// window accumulators. Depends on wrpe_pkg, wrpe_iter and the macros header.
//
// Usage: input items arrive on in_valid_i/in_item_i, one channel sample or an
// end-of-stream flush each, and are taken when in_stall_o is low. Every
// channel_count samples form a frame mixed to mono; each full window of
// window_frames frames, or a flush over a non-empty window, yields one result
// item (rms, peak, centre_frame, frame_count) on out_valid_o/out_item_o.
// Configuration is written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user
// must write it only when idle, as the block itself does not enforce it.
// A sample that closes a frame runs the mono divide on the bit-serial shared
// unit; a frame that closes a window then runs the mean divide and the square
// root, as does a flush of a non-empty window. in_stall_o stays high until
// the block is idle again, so no new item is taken while one is in work.
// The result turns valid as the block goes idle.
// One output register holds a finished result; a stalled receiver only holds
// up the block when a second result is ready to be loaded.
// Reset clears all counters and the output valid, and loads window_frames =
// 2400, channel_count = 1.
`include "windowed_rms_peak_envelope_top_macros.svh"

module windowed_rms_peak_envelope_top #(
  parameter int MAX_CHANNELS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [wrpe_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [wrpe_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  wrpe_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output wrpe_pkg::out_item_t                 out_item_o
);
  import wrpe_pkg::*;

  localparam int IDX_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int FSUM_W  = SAMPLE_BITS + IDX_W;
  localparam int MAG_W   = FSUM_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUMSQ_W = SQ_W + WIN_W;
  localparam int REM_W   = MAG_W + 2;
  localparam int CNT_W   = $clog2(SUMSQ_W + 1);
  localparam logic [CHAN_W:0] CH_MAX = (CHAN_W + 1)'(MAX_CHANNELS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX,
    S_SQR,
    S_ACC,
    S_EMIT,
    S_MEAN,
    S_ROOT,
    S_LOAD
  } state_e;

  // Configuration
  logic [WIN_W-1:0]  window_frames_q;
  logic [CHAN_W-1:0] channel_count_q;

  // Frame and window state
  state_e                    state_q;
  logic signed [FSUM_W-1:0]  fsum_q;
  logic [IDX_W-1:0]          idx_q;
  logic [MAG_W-1:0]          mag_q;
  logic [SQ_W-1:0]           sq_q;
  logic [SUMSQ_W-1:0]        sumsq_q;
  logic [MAG_W-1:0]          peak_q;
  logic [WIN_W-1:0]          wcnt_q;
  logic [TOTAL_W-1:0]        total_q;
  logic                      flush_q;
  logic [LEVEL_W-1:0]        pend_peak_q;
  logic [TOTAL_W-1:0]        pend_centre_q;
  logic [WIN_W-1:0]          pend_count_q;
  logic                      out_valid_q;
  out_item_t                 out_q;

  // Shared unit
  iter_req_t           eng_req;
  logic [CNT_W-1:0]    eng_steps;
  logic [SUMSQ_W-1:0]  eng_num;
  logic [DEN_W-1:0]    eng_den;
  logic                eng_busy;
  logic                eng_done;
  logic [SUMSQ_W-1:0]  eng_res;

  // Mixing
  logic [CHAN_W:0]          chans_eff;
  logic [CHAN_W:0]          idx_next;
  logic                     frame_done;
  logic signed [FSUM_W-1:0] sample_ext;
  logic signed [FSUM_W-1:0] fsum_add;
  logic [MAG_W-1:0]         mag_in;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_frames_q <= WIN_RESET;
      channel_count_q <= CHAN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WINDOW_FRAMES: window_frames_q <= cfg_wdata_i[WIN_W-1:0];
        REG_CHANNEL_COUNT: channel_count_q <= cfg_wdata_i[CHAN_W-1:0];
        default:           ;
      endcase
    end
  end

  // Effective channel count, running frame sum and its magnitude
  always_comb begin
    priority if (channel_count_q == '0) begin
      chans_eff = (CHAN_W + 1)'(1);
    end else if ({1'b0, channel_count_q} > CH_MAX) begin
      chans_eff = CH_MAX;
    end else begin
      chans_eff = {1'b0, channel_count_q};
    end
    idx_next   = (CHAN_W + 1)'(idx_q) + (CHAN_W + 1)'(1);
    frame_done = !(idx_next < chans_eff);
    sample_ext = {{(FSUM_W - SAMPLE_BITS){in_item_i.sample[SAMPLE_BITS-1]}},
                  in_item_i.sample};
    fsum_add   = fsum_q + sample_ext;
    mag_in     = fsum_add[FSUM_W-1] ? (~fsum_add + 1'b1) : fsum_add;
  end

  // Requests to the shared unit
  always_comb begin
    eng_req   = '{start: 1'b0, mode: MODE_DIV};
    eng_steps = '0;
    eng_num   = '0;
    eng_den   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && (in_item_i.cmd == CMD_SAMPLE) && frame_done) begin
          eng_req   = '{start: 1'b1, mode: MODE_DIV};
          eng_steps = CNT_W'(MAG_W);
          eng_num   = {mag_in, {(SUMSQ_W - MAG_W){1'b0}}};
          eng_den   = DEN_W'(chans_eff);
        end
      end
      S_EMIT: begin
        eng_req   = '{start: 1'b1, mode: MODE_DIV};
        eng_steps = CNT_W'(SUMSQ_W);
        eng_num   = sumsq_q;
        eng_den   = wcnt_q;
      end
      S_MEAN: begin
        if (eng_done) begin
          eng_req   = '{start: 1'b1, mode: MODE_SQRT};
          eng_steps = CNT_W'(MAG_W);
          eng_num   = {eng_res[SQ_W-1:0], {WIN_W{1'b0}}};
        end
      end
      default: ;
    endcase
  end

  wrpe_iter #(
    .NUM_W(SUMSQ_W),
    .REM_W(REM_W),
    .CNT_W(CNT_W)
  ) u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (eng_req),
    .steps_i(eng_steps),
    .num_i  (eng_num),
    .den_i  (eng_den),
    .busy_o (eng_busy),
    .done_o (eng_done),
    .res_o  (eng_res)
  );

  // Sequencer, accumulators and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      fsum_q        <= '0;
      idx_q         <= '0;
      mag_q         <= '0;
      sq_q          <= '0;
      sumsq_q       <= '0;
      peak_q        <= '0;
      wcnt_q        <= '0;
      total_q       <= '0;
      flush_q       <= 1'b0;
      pend_peak_q   <= '0;
      pend_centre_q <= '0;
      pend_count_q  <= '0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else begin
      // the load state refills the register itself
      if (out_valid_q && !out_stall_i && (state_q != S_LOAD)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            if (in_item_i.cmd == CMD_FLUSH) begin
              fsum_q <= '0;
              idx_q  <= '0;
              if (wcnt_q != '0) begin
                flush_q <= 1'b1;
                state_q <= S_EMIT;
              end else begin
                sumsq_q <= '0;
                peak_q  <= '0;
                total_q <= '0;
              end
            end else if (frame_done) begin
              fsum_q  <= '0;
              idx_q   <= '0;
              state_q <= S_MIX;
            end else begin
              fsum_q <= fsum_add;
              idx_q  <= idx_q + 1'b1;
            end
          end
        end
        S_MIX: begin
          if (eng_done) begin
            mag_q   <= eng_res[MAG_W-1:0];
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          sq_q <= mag_q * mag_q;
          if (mag_q > peak_q) begin
            peak_q <= mag_q;
          end
          wcnt_q  <= wcnt_q + 1'b1;
          total_q <= total_q + 1'b1;
          state_q <= S_ACC;
        end
        S_ACC: begin
          sumsq_q <= sumsq_q + SUMSQ_W'(sq_q);
          // a window length of zero acts as one: wcnt is at least one here
          if (wcnt_q >= window_frames_q) begin
            flush_q <= 1'b0;
            state_q <= S_EMIT;
          end else begin
            state_q <= S_IDLE;
          end
        end
        S_EMIT: begin
          // capture result fields, then clear the window for the next one
          pend_peak_q   <= peak_q[LEVEL_W-1:0];
          pend_centre_q <= total_q - TOTAL_W'(wcnt_q[WIN_W-1:1]);
          pend_count_q  <= wcnt_q;
          sumsq_q       <= '0;
          peak_q        <= '0;
          wcnt_q        <= '0;
          if (flush_q) begin
            total_q <= '0;
          end
          state_q <= S_MEAN;
        end
        S_MEAN: begin
          if (eng_done) begin
            state_q <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (eng_done) begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q        <= 1'b1;
            out_q.rms          <= eng_res[LEVEL_W-1:0];
            out_q.peak         <= pend_peak_q;
            out_q.centre_frame <= pend_centre_q;
            out_q.frame_count  <= pend_count_q;
            state_q            <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Checks
  `WRPE_ASSERT_PROP(a_idle_unit_free, (state_q == S_IDLE) |-> !eng_busy, "unit busy in idle")
  `WRPE_ASSERT_PROP(a_done_awaited, eng_done |-> (state_q == S_MIX || state_q == S_MEAN || state_q == S_ROOT), "unexpected unit done")
  `WRPE_ASSERT_PROP(a_out_from_load, $rose(out_valid_q) |-> $past(state_q == S_LOAD), "result not from load")
  `WRPE_ASSERT_NEVER(a_no_empty_window, out_valid_q && (out_q.frame_count == '0), "empty window emitted")

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench of windowed_rms_peak_envelope_top: a directed table, then random phases.
// Each phase sets the window and the channel count and then sends items through the block.
// Every result item is checked against an envelope predictor in the bench. Needs wrpe_pkg and the RTL.
module testbench;
  import wrpe_pkg::*;

  localparam int     MAX_CHAN      = 8;
  localparam int     CLK_PERIOD    = 10;
  localparam int     SETTLE_CYCLES = 256;  // > two window closes of the shared divide/root unit
  localparam int     DRAIN_CYCLES  = 256;
  localparam int     LONG_HOLD     = 400;
  localparam int     PHASES        = 12;
  localparam int     PHASE_ITEMS   = 50;
  localparam int     MAX_PRINTS    = 100;
  localparam longint RUN_LIMIT_NS  = 64'd10_000_000;

  typedef enum logic [1:0] {
    ROW_REG,
    ROW_ITEM,
    ROW_CHECKED
  } row_kind_e;

  typedef struct packed {
    row_kind_e             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    in_item_t              item;
    out_item_t             want;
  } stim_row_t;

  // DUT connections
  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;

  // Stimulus control
  stim_row_t stim_rows[$];
  out_item_t pending_windows[$];
  int        sender_idle_pct    = 0;
  int        receiver_stall_pct = 0;
  int        hold_requests      = 0;
  int        mismatch_count     = 0;

  // Predictor state
  logic [15:0] cfg_window;
  logic [3:0]  cfg_channels;
  longint      mix_sum;
  int          mix_idx;
  logic [63:0] win_sq_sum;
  logic [15:0] win_peak;
  logic [15:0] win_frames_seen;
  logic [39:0] stream_frames;

  windowed_rms_peak_envelope_top #(
    .MAX_CHANNELS(MAX_CHAN)
  ) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_item_o (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Close the current window: rms by bitwise root search, then clear it
  function automatic out_item_t close_window();
    logic [63:0] mean;
    logic [63:0] root;
    logic [63:0] trial;
    int          b;
    out_item_t   r;
    mean = win_sq_sum / win_frames_seen;
    root = '0;
    for (b = 16; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= mean) root = trial;
    end
    r.rms          = root[15:0];
    r.peak         = win_peak;
    r.centre_frame = stream_frames - (win_frames_seen >> 1);
    r.frame_count  = win_frames_seen;
    win_sq_sum      = '0;
    win_peak        = '0;
    win_frames_seen = '0;
    return r;
  endfunction

  // Advance the envelope by one item; returns 1 when a window result comes out
  function automatic bit envelope_step(input in_item_t it, output out_item_t res);
    int          chans;
    logic [15:0] win_len;
    longint      mono;
    logic [63:0] mag;
    bit          hit;
    res     = '0;
    chans   = (cfg_channels == 0) ? 1 :
              ((cfg_channels > MAX_CHAN) ? MAX_CHAN : int'(cfg_channels));
    win_len = (cfg_window == 0) ? 16'd1 : cfg_window;
    // flush: drop partial frame, emit a non-empty window, restart the stream
    if (it.cmd == CMD_FLUSH) begin
      mix_sum = 0;
      mix_idx = 0;
      hit     = (win_frames_seen != 0);
      if (hit) res = close_window();
      stream_frames = '0;
      return hit;
    end
    mix_sum += $signed(it.sample);
    if (mix_idx + 1 < chans) begin
      mix_idx = mix_idx + 1;
      return 1'b0;
    end
    // frame complete: mono mix truncates toward zero
    mono    = mix_sum / chans;
    mix_sum = 0;
    mix_idx = 0;
    mag     = (mono < 0) ? -mono : mono;
    win_sq_sum += mag * mag;
    if (mag > win_peak) win_peak = mag[15:0];
    win_frames_seen = win_frames_seen + 16'd1;
    stream_frames   = stream_frames + 40'd1;
    if (win_frames_seen >= win_len) begin
      res = close_window();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [15:0] rand_sample();
    logic [15:0] v;
    case ($urandom_range(9))
      0:       v = 16'h8000;
      1:       v = 16'h7FFF;
      2, 3:    v = 16'($urandom_range(0, 64) - 32);
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS) $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r         = '0;
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    stim_rows = {stim_rows, r};
  endtask

  task automatic add_item(input logic cmd, input logic [15:0] smp);
    stim_row_t r;
    r             = '0;
    r.kind        = ROW_ITEM;
    r.item.cmd    = cmd;
    r.item.sample = smp;
    stim_rows = {stim_rows, r};
  endtask

  task automatic add_checked(input logic cmd, input logic [15:0] smp, input int rms,
                             input int peak, input longint centre, input int count);
    stim_row_t r;
    r                   = '0;
    r.kind              = ROW_CHECKED;
    r.item.cmd          = cmd;
    r.item.sample       = smp;
    r.want.rms          = 16'(rms);
    r.want.peak         = 16'(peak);
    r.want.centre_frame = 40'(centre);
    r.want.frame_count  = 16'(count);
    stim_rows = {stim_rows, r};
  endtask

  // Drop valid, wait for all windows to come out, then let the block go quiet
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_FRAMES) cfg_window = val;
    else cfg_channels = val[3:0];
  endtask

  // Offer one item after a random gap, hold it until taken, then predict
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t typed_res);
    out_item_t res;
    bit        has_res;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    has_res = envelope_step(it, res);
    if (typed) pending_windows = {pending_windows, typed_res};
    else if (has_res) pending_windows = {pending_windows, res};
  endtask

  // Receiver: random stalls, plus a long hold on request
  initial begin : receiver
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (hold_requests > holds_served) begin
        holds_served++;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
    end
  end

  // Result check against the oldest expected window
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_windows.size() == 0) begin
        report_mismatch("result item with no window expected");
      end else begin
        want = pending_windows.pop_front();
        if (out_item.rms !== want.rms)
          report_mismatch($sformatf("rms got %0d want %0d", out_item.rms, want.rms));
        if (out_item.peak !== want.peak)
          report_mismatch($sformatf("peak got %0d want %0d", out_item.peak, want.peak));
        if (out_item.centre_frame !== want.centre_frame)
          report_mismatch($sformatf("centre_frame got %0d want %0d",
                                    out_item.centre_frame, want.centre_frame));
        if (out_item.frame_count !== want.frame_count)
          report_mismatch($sformatf("frame_count got %0d want %0d",
                                    out_item.frame_count, want.frame_count));
      end
    end
  end

  initial begin : stimulus
    stim_row_t   row;
    in_item_t    it;
    logic [15:0] win_val;
    logic [3:0]  chan_val;
    logic [11:0] upper;

    cfg_window      = WIN_RESET;
    cfg_channels    = CHAN_RESET;
    mix_sum         = 0;
    mix_idx         = 0;
    win_sq_sum      = '0;
    win_peak        = '0;
    win_frames_seen = '0;
    stream_frames   = '0;

    // Directed table
    // reset values: 2400-frame window, mono; flush closes a two-frame window
    add_item(CMD_SAMPLE, 16'h7FFF);
    add_item(CMD_SAMPLE, 16'h8000);
    add_checked(CMD_FLUSH, 16'h0000, 32767, 32768, 1, 2);
    // flush of an empty window gives nothing
    add_item(CMD_FLUSH, 16'hFFFF);
    add_reg(REG_WINDOW_FRAMES, 16'd1);
    add_checked(CMD_SAMPLE, 16'h8000, 32768, 32768, 1, 1);
    // zero window length acts as one
    add_reg(REG_WINDOW_FRAMES, 16'd0);
    add_checked(CMD_SAMPLE, 16'h0001, 1, 1, 2, 1);
    add_item(CMD_FLUSH, 16'h0000);
    // zero channels acts as one
    add_reg(REG_CHANNEL_COUNT, 16'd0);
    add_checked(CMD_SAMPLE, -16'sd5, 5, 5, 1, 1);
    // all-ones write: channel count 15 clamps to eight
    add_reg(REG_CHANNEL_COUNT, 16'hFFFF);
    repeat (7) add_item(CMD_SAMPLE, 16'h8000);
    add_checked(CMD_SAMPLE, 16'h8000, 32768, 32768, 2, 1);
    // three channels: -2 / 3 truncates to zero
    add_reg(REG_CHANNEL_COUNT, 16'd3);
    add_item(CMD_SAMPLE, 16'hFFFF);
    add_item(CMD_SAMPLE, 16'hFFFF);
    add_checked(CMD_SAMPLE, 16'h0000, 0, 0, 3, 1);
    // channel count lowered mid-frame: next sample closes the frame
    add_reg(REG_CHANNEL_COUNT, 16'd4);
    add_item(CMD_SAMPLE, 16'd100);
    add_item(CMD_SAMPLE, 16'd200);
    add_reg(REG_CHANNEL_COUNT, 16'd2);
    add_checked(CMD_SAMPLE, 16'd300, 300, 300, 4, 1);
    // window lowered mid-window: closes at the next frame with three frames
    add_reg(REG_WINDOW_FRAMES, 16'hFFFF);
    add_reg(REG_CHANNEL_COUNT, 16'd1);
    add_item(CMD_SAMPLE, 16'd7);
    add_item(CMD_SAMPLE, -16'sd9);
    add_reg(REG_WINDOW_FRAMES, 16'd2);
    add_checked(CMD_SAMPLE, 16'd3, 6, 9, 6, 3);
    // longest window, closed by flush
    add_reg(REG_WINDOW_FRAMES, 16'hFFFF);
    add_item(CMD_SAMPLE, 16'h8000);
    add_checked(CMD_FLUSH, 16'h1234, 32768, 32768, 8, 1);

    sender_idle_pct    = 16;
    receiver_stall_pct = 52;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      case (row.kind)
        ROW_REG:  write_reg(row.reg_idx, row.reg_val);
        ROW_ITEM: send_item(row.item, 1'b0, '0);
        default:  send_item(row.item, 1'b1, row.want);
      endcase
    end

    // Random phases: each sets both registers, then sends items ending in a flush
    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 4) begin
        sender_idle_pct    = 52;
        receiver_stall_pct = 16;
      end
      if (ph == 8) begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
      end
      case (ph)
        0: begin
          win_val  = 16'd1;
          chan_val = 4'd1;
        end
        1: begin
          win_val  = 16'd0;
          chan_val = 4'd15;
        end
        2: begin
          win_val  = 16'hFFFF;
          chan_val = 4'd8;
        end
        3: begin
          win_val  = 16'($urandom_range(1, 6));
          chan_val = 4'd0;
        end
        8: begin
          win_val  = 16'($urandom_range(1, 2));
          chan_val = 4'd1;
        end
        default: begin
          win_val  = ($urandom_range(7) == 0) ? 16'($urandom_range(7, 400))
                                              : 16'($urandom_range(1, 5));
          chan_val = ($urandom_range(5) == 0) ? 4'($urandom_range(0, 15))
                                              : 4'($urandom_range(1, 3));
        end
      endcase
      upper = ($urandom_range(1) == 0) ? 12'h000 : 12'($urandom());
      write_reg(REG_WINDOW_FRAMES, win_val);
      write_reg(REG_CHANNEL_COUNT, {upper, chan_val});
      // long receiver hold while items keep coming: block must back up
      if (ph == 0 || ph == 8) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS - 1; n++) begin
        it.cmd    = ($urandom_range(29) == 0) ? CMD_FLUSH : CMD_SAMPLE;
        it.sample = rand_sample();
        send_item(it, 1'b0, '0);
      end
      it.cmd    = CMD_FLUSH;
      it.sample = rand_sample();
      send_item(it, 1'b0, '0);
    end

    // Drain, then watch for stray results
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_windows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RUN_LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
